// ===== hdl/qmi_pkg.sv =====
// Shared types and codes for the queue with middle insertion.
// Used by qmi_ctrl, qmi_datapath and queue_with_middle_insert_top; no dependencies.
package qmi_pkg;

  // Fixed field widths of the item and result channels
  localparam int unsigned OP_WIDTH     = 2;
  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned STATUS_WIDTH = 2;
  localparam int unsigned QLEN_WIDTH   = 11;

  // Operation codes
  localparam logic [OP_WIDTH-1:0] OP_PUSH_BACK = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_PUSH_MID  = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_POP       = 2'd2;

  // Result status codes
  localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic exec;  // decode and apply the accepted operation
    logic move;  // move the back half's head to the front half's tail
    logic load;  // load the result register
  } qmi_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_move;  // the operation being applied needs a rebalancing move
  } qmi_sts_t;

endpackage

// ===== hdl/queue_with_middle_insert_top.sv =====
// Queue with middle insertion: FIFO held as two circular half buffers.
// Usage:
//   Input channel (in_valid/in_ready) carries operation and value. Operation
//   push-back appends to the queue tail, push-middle inserts right after the
//   first ceil(k/2) items, pop removes and returns the head.
//   Output channel (out_valid/out_ready) carries one result per operation:
//   popped_value (zero unless a pop succeeded), status (ok, pop from empty,
//   push rejected because full) and queue_length after the operation.
// Result: loaded into the result register in the publish state, straight after
//   the transfer or after a move state that brings a back-half item to the front.
// Throughput: one item per cycle while the result channel does not stall; a
//   rebalancing move holds the input for the move state. The move reads the back
//   half's head through its registered read port and writes it to the front half's tail in the next cycle.
// Reset: rst (synchronous) empties the queue and drops any pending result;
//   buffer contents are left as they are and never read before written.
// Stall: one result register parts the channels; a new item is taken while a
//   result waits, and the block holds after that until the result is taken.
// Depends on qmi_pkg, qmi_ctrl and qmi_datapath.
module queue_with_middle_insert_top #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [qmi_pkg::OP_WIDTH-1:0]           operation,
  input  logic signed [qmi_pkg::VALUE_WIDTH-1:0] value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [qmi_pkg::VALUE_WIDTH-1:0] popped_value,
  output logic [qmi_pkg::STATUS_WIDTH-1:0]       status,
  output logic [qmi_pkg::QLEN_WIDTH-1:0]         queue_length
);

  // Command and status between the sequencer and the buffers
  qmi_pkg::qmi_cmd_t cmd;
  qmi_pkg::qmi_sts_t sts;

  // Sequence each transfer: apply, optional rebalance, load result
  qmi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Hold both halves, their pointers and counts, and the result register
  qmi_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .operation    (operation),
    .value        (value),
    .popped_value (popped_value),
    .status       (status),
    .queue_length (queue_length)
  );

endmodule

// ===== hdl/qmi_datapath.sv =====
// Datapath: front and back half buffers, their pointers and counts, result register.
// Depends on qmi_pkg; driven by qmi_ctrl through qmi_cmd_t.
module qmi_datapath #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  qmi_pkg::qmi_cmd_t                    cmd,
  output qmi_pkg::qmi_sts_t                    sts,
  input  logic [qmi_pkg::OP_WIDTH-1:0]         operation,
  input  logic signed [qmi_pkg::VALUE_WIDTH-1:0] value,
  output logic signed [qmi_pkg::VALUE_WIDTH-1:0] popped_value,
  output logic [qmi_pkg::STATUS_WIDTH-1:0]     status,
  output logic [qmi_pkg::QLEN_WIDTH-1:0]       queue_length
);

  localparam int unsigned HD = (CAPACITY + 1) / 2;
  localparam int unsigned PW = (HD > 1) ? $clog2(HD) : 1;
  localparam int unsigned CW = $clog2(HD + 1);
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = ((PW > CW) ? PW : CW) + 1;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] head,
                                             input logic [CW-1:0] cnt);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(cnt);
    if (s >= SW'(HD)) s = s - SW'(HD);
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(HD - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(HD - 1) : p - PW'(1);
  endfunction

  logic [DATA_WIDTH-1:0] front_mem [0:HD-1];
  logic [DATA_WIDTH-1:0] back_mem  [0:HD-1];
  logic [DATA_WIDTH-1:0] front_rd;
  logic [DATA_WIDTH-1:0] back_rd;

  logic [PW-1:0] front_head, front_head_next;
  logic [PW-1:0] back_head, back_head_next;
  logic [CW-1:0] front_count, front_count_next;
  logic [CW-1:0] back_count, back_count_next;

  logic [qmi_pkg::STATUS_WIDTH-1:0] res_status, res_status_next;
  logic                             res_pop, res_pop_next;

  logic                  front_we, front_re, back_we, back_re;
  logic [PW-1:0]         front_wa, back_wa;
  logic [DATA_WIDTH-1:0] front_wd, back_wd;
  logic [DATA_WIDTH-1:0] item;
  logic [LW-1:0]         total;
  logic                  full;

  assign item  = DATA_WIDTH'($unsigned(value));
  assign total = LW'(front_count) + LW'(back_count);
  assign full  = (total >= LW'(CAPACITY));

  always_comb begin
    front_we         = 1'b0;
    front_re         = 1'b0;
    back_we          = 1'b0;
    back_re          = 1'b0;
    front_wa         = wrap_add(front_head, front_count);
    back_wa          = wrap_add(back_head, back_count);
    front_wd         = item;
    back_wd          = item;
    front_head_next  = front_head;
    back_head_next   = back_head;
    front_count_next = front_count;
    back_count_next  = back_count;
    res_status_next  = res_status;
    res_pop_next     = res_pop;
    sts.need_move    = 1'b0;
    if (cmd.exec) begin
      res_status_next = qmi_pkg::ST_OK;
      res_pop_next    = 1'b0;
      unique case (operation)
        qmi_pkg::OP_PUSH_BACK: begin
          if (full) begin
            res_status_next = qmi_pkg::ST_FULL;
          end else if (front_count == '0) begin
            // empty queue: the item lands straight in the front half
            front_we         = 1'b1;
            front_count_next = front_count + CW'(1);
          end else begin
            back_we         = 1'b1;
            back_count_next = back_count + CW'(1);
            if (front_count == back_count) begin
              back_re       = 1'b1;
              sts.need_move = 1'b1;
            end
          end
        end
        qmi_pkg::OP_PUSH_MID: begin
          if (full) begin
            res_status_next = qmi_pkg::ST_FULL;
          end else if (front_count > back_count) begin
            back_we         = 1'b1;
            back_wa         = wrap_dec(back_head);
            back_head_next  = wrap_dec(back_head);
            back_count_next = back_count + CW'(1);
          end else begin
            front_we         = 1'b1;
            front_count_next = front_count + CW'(1);
          end
        end
        qmi_pkg::OP_POP: begin
          if (front_count == '0) begin
            res_status_next = qmi_pkg::ST_EMPTY;
          end else begin
            front_re         = 1'b1;
            res_pop_next     = 1'b1;
            front_head_next  = wrap_inc(front_head);
            front_count_next = front_count - CW'(1);
            if (front_count == back_count) begin
              back_re       = 1'b1;
              sts.need_move = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.move) begin
      front_we         = 1'b1;
      front_wd         = back_rd;
      front_count_next = front_count + CW'(1);
      back_head_next   = wrap_inc(back_head);
      back_count_next  = back_count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_head  <= '0;
      back_head   <= '0;
      front_count <= '0;
      back_count  <= '0;
    end else begin
      front_head  <= front_head_next;
      back_head   <= back_head_next;
      front_count <= front_count_next;
      back_count  <= back_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (front_we) front_mem[front_wa] <= front_wd;
    if (front_re) front_rd <= front_mem[front_head];
  end

  always_ff @(posedge clk) begin
    if (back_we) back_mem[back_wa] <= back_wd;
    if (back_re) back_rd <= back_mem[back_head];
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_pop    <= res_pop_next;
    if (cmd.load) begin
      popped_value <= res_pop ? qmi_pkg::VALUE_WIDTH'(front_rd) : '0;
      status       <= res_status;
      queue_length <= qmi_pkg::QLEN_WIDTH'(total);
    end
  end

endmodule

// ===== hdl/qmi_ctrl.sv =====
// Controller: sequences accept, rebalancing move and result load; owns both handshakes.
// Depends on qmi_pkg; commands qmi_datapath.
module qmi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output qmi_pkg::qmi_cmd_t cmd,
  input  qmi_pkg::qmi_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MOVE = 3'b010,
    S_PUB  = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) || ((state == S_PUB) && out_free);
  assign accept   = in_valid && in_ready;

  assign cmd.exec = accept;
  assign cmd.move = (state == S_MOVE);
  assign cmd.load = (state == S_PUB) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = sts.need_move ? S_MOVE : S_PUB;
      end
      S_MOVE: begin
        state_next = S_PUB;
      end
      S_PUB: begin
        if (out_free) begin
          if (accept) state_next = sts.need_move ? S_MOVE : S_PUB;
          else state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_move_after_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |-> $past(accept && sts.need_move))
    else $error("move cycle without a preceding operation that needs it");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted operation left no pending work");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUB && out_valid && !out_ready) |=> (state == S_PUB))
    else $error("pending result dropped while receiver stalls");

endmodule
